// File: hw/rtl/tfpp_pkg.sv
// Shared types and constants for the touch frame point parser.
`default_nettype none

package tfpp_pkg;

   localparam logic OP_FRAME_BYTE = 1'b0;
   localparam logic OP_RELEASE    = 1'b1;

   localparam logic [2:0] CSR_SWAP_AXES     = 3'd0;
   localparam logic [2:0] CSR_MIRROR_HORIZ  = 3'd1;
   localparam logic [2:0] CSR_MIRROR_VERT   = 3'd2;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd4;

   localparam logic [12:0] SCREEN_SIZE_RESET = 13'd412;

   localparam logic [7:0] GESTURE_MARK  = 8'hF6;
   localparam logic [6:0] MARK_POS      = 7'd4;
   localparam logic [6:0] FIRST_REC_POS = 7'd5;
   localparam logic [6:0] REC_LEN       = 7'd6;
   localparam logic [6:0] MIN_FRAME_LEN = 7'd10;
   localparam logic [6:0] POS_LIMIT     = 7'd127;

   typedef struct packed {
      logic       op;
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } req_beat_type;

   typedef struct packed {
      logic        pressed;
      logic [15:0] touch_x;
      logic [15:0] touch_y;
      logic [2:0]  point_count;
   } rsp_beat_type;

   typedef struct packed {
      logic        swap_axes;
      logic        mirror_horizontal;
      logic        mirror_vertical;
      logic [12:0] screen_width;
      logic [12:0] screen_height;
   } cfg_type;

   typedef struct packed {
      logic        emit;
      logic [2:0]  count;
      logic [11:0] raw_x;
      logic [11:0] raw_y;
   } frame_summary_type;

endpackage

`default_nettype wire

// File: hw/rtl/tfpp_frame_parser.sv
// Frame byte tracker: byte position, gesture mark, record count and first point capture.
`default_nettype none

module tfpp_frame_parser #(
   parameter int MAX_RECORDS     = 5,
   parameter int MAX_FRAME_BYTES = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire tfpp_pkg::req_beat_type     beat,
   output tfpp_pkg::frame_summary_type     summary
);
   import tfpp_pkg::*;

   localparam logic [6:0] FRAME_LIMIT = 7'(MAX_FRAME_BYTES);
   localparam logic [2:0] POINT_LIMIT = 3'(MAX_RECORDS);
   localparam logic [6:0] FIRST_HIT   = MIN_FRAME_LEN - 7'd1;

   logic [6:0]  pos_ff, pos_in;
   logic        gesture_ff, gesture_in;
   logic [2:0]  records_ff, records_in;
   logic [6:0]  next_rec_ff, next_rec_in;
   logic [7:0]  x_low_ff, x_low_in;
   logic [7:0]  y_low_ff, y_low_in;
   logic [11:0] raw_x_ff, raw_x_in;
   logic [11:0] raw_y_ff, raw_y_in;

   logic [6:0]  w_pos;
   logic        w_gesture;
   logic [2:0]  w_records;
   logic [6:0]  w_next_rec;
   logic [7:0]  w_x_low;
   logic [7:0]  w_y_low;
   logic [11:0] w_raw_x;
   logic [11:0] w_raw_y;
   logic        clear;

   always_comb begin
      w_pos      = pos_ff;
      w_gesture  = gesture_ff;
      w_records  = records_ff;
      w_next_rec = next_rec_ff;
      w_x_low    = x_low_ff;
      w_y_low    = y_low_ff;
      w_raw_x    = raw_x_ff;
      w_raw_y    = raw_y_ff;
      summary    = '0;
      clear      = 1'b0;

      if (beat.op == OP_RELEASE) begin
         clear        = 1'b1;
         summary.emit = 1'b1;
      end else begin
         if (pos_ff < FRAME_LIMIT) begin
            if (pos_ff == MARK_POS) begin
               w_gesture = (beat.frame_byte == GESTURE_MARK);
            end else if (pos_ff == FIRST_REC_POS) begin
               w_x_low = beat.frame_byte;
            end else if (pos_ff == FIRST_REC_POS + 7'd1) begin
               w_y_low = beat.frame_byte;
            end else if (pos_ff == FIRST_REC_POS + 7'd2) begin
               w_raw_x = {beat.frame_byte[7:4], x_low_ff};
               w_raw_y = {beat.frame_byte[3:0], y_low_ff};
            end
            if (pos_ff == next_rec_ff && records_ff < POINT_LIMIT) begin
               w_records  = records_ff + 3'd1;
               w_next_rec = next_rec_ff + REC_LEN;
            end
         end
         if (pos_ff != POS_LIMIT) begin
            w_pos = pos_ff + 7'd1;
         end
         clear         = beat.end_of_frame;
         summary.emit  = beat.end_of_frame;
         summary.count = w_gesture ? 3'd0 : w_records;
         summary.raw_x = w_raw_x;
         summary.raw_y = w_raw_y;
      end

      if (clear) begin
         pos_in      = '0;
         gesture_in  = 1'b0;
         records_in  = '0;
         next_rec_in = FIRST_HIT;
         x_low_in    = '0;
         y_low_in    = '0;
         raw_x_in    = '0;
         raw_y_in    = '0;
      end else begin
         pos_in      = w_pos;
         gesture_in  = w_gesture;
         records_in  = w_records;
         next_rec_in = w_next_rec;
         x_low_in    = w_x_low;
         y_low_in    = w_y_low;
         raw_x_in    = w_raw_x;
         raw_y_in    = w_raw_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         gesture_ff  <= 1'b0;
         records_ff  <= '0;
         next_rec_ff <= FIRST_HIT;
         x_low_ff    <= '0;
         y_low_ff    <= '0;
         raw_x_ff    <= '0;
         raw_y_ff    <= '0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         gesture_ff  <= gesture_in;
         records_ff  <= records_in;
         next_rec_ff <= next_rec_in;
         x_low_ff    <= x_low_in;
         y_low_ff    <= y_low_in;
         raw_x_ff    <= raw_x_in;
         raw_y_ff    <= raw_y_in;
      end
   end

   a_records_capped: assert property (@(posedge clock) disable iff (reset)
      records_ff <= POINT_LIMIT)
      else $error("Record count passed the point limit.");

   a_frame_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && summary.emit) |=> (pos_ff == 7'd0 && records_ff == 3'd0))
      else $error("Frame state was not cleared after a result.");

endmodule

`default_nettype wire

// File: hw/rtl/tfpp_point_xform.sv
// Swap and mirror of the first point, and the held coordinates for releases.
`default_nettype none

module tfpp_point_xform (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        commit,
   input  wire tfpp_pkg::cfg_type           cfg,
   input  wire tfpp_pkg::frame_summary_type summary,
   output tfpp_pkg::rsp_beat_type           result
);
   import tfpp_pkg::*;

   logic [15:0] held_x_ff;
   logic [15:0] held_y_ff;
   logic [15:0] sw_x;
   logic [15:0] sw_y;
   logic [15:0] new_x;
   logic [15:0] new_y;
   logic        has_point;

   always_comb begin
      if (cfg.swap_axes) begin
         sw_x = {4'd0, summary.raw_y};
         sw_y = {4'd0, summary.raw_x};
      end else begin
         sw_x = {4'd0, summary.raw_x};
         sw_y = {4'd0, summary.raw_y};
      end
      if (cfg.mirror_horizontal && cfg.screen_width != 13'd0) begin
         new_x = {3'd0, cfg.screen_width} - 16'd1 - sw_x;
      end else begin
         new_x = sw_x;
      end
      if (cfg.mirror_vertical && cfg.screen_height != 13'd0) begin
         new_y = {3'd0, cfg.screen_height} - 16'd1 - sw_y;
      end else begin
         new_y = sw_y;
      end
      has_point          = (summary.count != 3'd0);
      result.pressed     = has_point;
      result.touch_x     = has_point ? new_x : held_x_ff;
      result.touch_y     = has_point ? new_y : held_y_ff;
      result.point_count = summary.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
      end else if (commit && has_point) begin
         held_x_ff <= new_x;
         held_y_ff <= new_y;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tfpp_rsp_buffer.sv
// Result register with a skid stage so the upstream side can keep moving.
`default_nettype none

module tfpp_rsp_buffer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire tfpp_pkg::rsp_beat_type  push_data,
   output logic                         room,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output tfpp_pkg::rsp_beat_type       rsp_data
);
   import tfpp_pkg::*;

   logic         out_valid_ff;
   logic         skid_valid_ff;
   rsp_beat_type out_data_ff;
   rsp_beat_type skid_data_ff;
   logic         pop;

   assign pop       = out_valid_ff && rsp_ready;
   assign room      = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= push_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= push_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid stage holds a beat while the output stage is empty.");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("Result pushed while both stages were full.");

endmodule

`default_nettype wire

// File: hw/rtl/touch_frame_point_parser_top.sv
// Top level of the touch frame point parser.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_data: op, frame_byte, end_of_frame
//   rsp      out        rsp_valid/rsp_ready    rsp_data: pressed, touch_x, touch_y, point_count
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// One beat per cycle is accepted while req_ready is high. A beat is held in the input register,
// then the frame state and the point transform settle combinationally into the result register,
// so rsp_valid rises once the result register takes the result of the beat causing it. A skid stage
// behind the result register takes one more result while the output is stalled; after that
// the input register holds its beat and req_ready drops.
// Reset is synchronous: it clears frame state, held coordinates and valid flags, and loads CSR defaults.
`default_nettype none

module touch_frame_point_parser_top #(
   parameter int MAX_RECORDS     = 5,
   parameter int MAX_FRAME_BYTES = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tfpp_pkg::req_beat_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tfpp_pkg::rsp_beat_type      rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [2:0]             csr_index,
   input  wire logic [12:0]            csr_wdata
);
   import tfpp_pkg::*;

   cfg_type           cfg_ff;
   logic              in_valid_ff;
   req_beat_type      in_beat_ff;
   logic              room;
   logic              advance;
   logic              push;
   frame_summary_type summary;
   rsp_beat_type      result;

   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || advance;
   assign push      = advance && summary.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_axes         <= 1'b0;
         cfg_ff.mirror_horizontal <= 1'b0;
         cfg_ff.mirror_vertical   <= 1'b0;
         cfg_ff.screen_width      <= SCREEN_SIZE_RESET;
         cfg_ff.screen_height     <= SCREEN_SIZE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SWAP_AXES:     cfg_ff.swap_axes         <= csr_wdata[0];
            CSR_MIRROR_HORIZ:  cfg_ff.mirror_horizontal <= csr_wdata[0];
            CSR_MIRROR_VERT:   cfg_ff.mirror_vertical   <= csr_wdata[0];
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width      <= csr_wdata;
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_beat_ff <= req_data;
      end
   end

   tfpp_frame_parser #(
      .MAX_RECORDS     (MAX_RECORDS),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .beat    (in_beat_ff),
      .summary (summary)
   );

   tfpp_point_xform u_xform (
      .clock   (clock),
      .reset   (reset),
      .commit  (push),
      .cfg     (cfg_ff),
      .summary (summary),
      .result  (result)
   );

   tfpp_rsp_buffer u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_release_not_pressed: assert property (@(posedge clock) disable iff (reset)
      (push && in_beat_ff.op == OP_RELEASE) |-> (!result.pressed && result.point_count == 3'd0))
      else $error("A release produced a pressed result.");

endmodule

`default_nettype wire
